@@ rtl/spq_pkg.sv @@
// shared types, codes and the level to score table of the priority queue
package spq_pkg;

	localparam int TAG_W   = 16;
	localparam int SCORE_W = 7;
	localparam int LEVEL_W = 3;
	localparam int OCC_W   = 5;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [SCORE_W-1:0] score;
	} entry_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t fresh;
	} cmd_t;

	// levels outside one to five are clamped
	function automatic logic [SCORE_W-1:0] level_to_score(input logic [LEVEL_W-1:0] level);
		logic [SCORE_W-1:0] score;
		case (level)
			3'd0:    score = 7'd100;
			3'd1:    score = 7'd100;
			3'd2:    score = 7'd80;
			3'd3:    score = 7'd60;
			3'd4:    score = 7'd40;
			default: score = 7'd20;
		endcase
		return score;
	endfunction

endpackage

@@ rtl/spq_if.sv @@
// valid/ready channels of the priority queue: request and response
interface spq_req_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [LEVEL_W-1:0] urgency_level;
	logic [TAG_W-1:0]   entry_tag;

	modport source(output valid, output mode, output urgency_level, output entry_tag,
		input ready);
	modport sink(input valid, input mode, input urgency_level, input entry_tag,
		output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [TAG_W-1:0]   removed_tag;
	logic [SCORE_W-1:0] removed_score;
	logic               head_valid;
	logic [TAG_W-1:0]   head_tag;
	logic [SCORE_W-1:0] head_score;
	logic [OCC_W-1:0]   occupancy;

	modport source(output valid, output status, output removed_tag, output removed_score,
		output head_valid, output head_tag, output head_score, output occupancy,
		input ready);
	modport sink(input valid, input status, input removed_tag, input removed_score,
		input head_valid, input head_tag, input head_score, input occupancy,
		output ready);
endinterface

@@ rtl/spq_cell.sv @@
// one slot of the sorted chain: keeps, takes the new entry, or shifts
module spq_cell import spq_pkg::*; (
	input  logic   clk,
	input  cmd_t   cmd,
	input  logic   occ,
	input  logic   prev_ge,
	input  entry_t prev_entry,
	input  entry_t next_entry,
	output entry_t entry,
	output logic   ge
);

	entry_t entry_q;

	// stored entry ranks at or above the new one, so it stays put
	assign ge    = occ && (entry_q.score >= cmd.fresh.score);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!ge) begin
				if (prev_ge) begin
					entry_q <= cmd.fresh;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (cmd.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ rtl/stable_priority_queue.sv @@
// top level of the stable priority queue: cell chain, fill count, response register
// Bounded priority queue of DEPTH entries kept in descending score order in a
// chain of cells, one entry per cell. An insert beat turns its urgency level
// (clamped to one to five) into the score (6 - level) * 20 and lands behind
// every stored entry of equal or higher score, so equal scores leave in arrival
// order; a remove beat takes the head out. Every request gives one response
// beat with the status, the removed entry, the head and the occupancy after
// the step. All cells compare against the new score at once and shift in the
// same edge, and the response register lets a new request in while the
// previous response is being taken, so a beat per cycle is sustained while rsp
// ready stays high. Occupancy is reported in five bits, masked to that width.
module stable_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      count_q;
	logic               rsp_valid_q;
	status_t            status_q;
	logic [TAG_W-1:0]   removed_tag_q;
	logic [SCORE_W-1:0] removed_score_q;

	logic   accept;
	logic   full;
	logic   empty;
	cmd_t   cmd;
	entry_t cell_entry [DEPTH];
	logic   cell_ge    [DEPTH];

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign accept = req.valid && req.ready;

	assign req.ready = !rsp_valid_q || rsp.ready;

	assign cmd.ins         = accept && (req.mode == MODE_INSERT) && !full;
	assign cmd.rem         = accept && (req.mode == MODE_REMOVE) && !empty;
	assign cmd.fresh.tag   = req.entry_tag;
	assign cmd.fresh.score = level_to_score(req.urgency_level);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   prev_ge;
		entry_t prev_entry;
		entry_t next_entry;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_ge    = 1'b1;
			assign prev_entry = cmd.fresh;
		end else begin : g_rest
			assign prev_ge    = cell_ge[i-1];
			assign prev_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_entry = cell_entry[i];
		end else begin : g_mid
			assign next_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ),
			.prev_ge    (prev_ge),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (cell_entry[i]),
			.ge         (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.mode == MODE_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_OK;
			end
			removed_tag_q   <= cmd.rem ? cell_entry[0].tag : '0;
			removed_score_q <= cmd.rem ? cell_entry[0].score : '0;
		end
	end

	// head comes straight from the chain and occupancy from the fill count, both only move on a beat
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_tag   = removed_tag_q;
	assign rsp.removed_score = removed_score_q;
	assign rsp.head_valid    = !empty;
	assign rsp.head_tag      = empty ? '0 : cell_entry[0].tag;
	assign rsp.head_score    = empty ? '0 : cell_entry[0].score;
	assign rsp.occupancy     = OCC_W'(count_q);

endmodule

@@ dv/stable_priority_queue_tb.sv @@
// self-checking testbench of the stable priority queue: directed table, then random beats
module stable_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_BEATS = 1800;
	localparam int QUIET_LIMIT  = 1000;
	localparam int LONG_HOLD    = 120;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		status_t            status;
		logic [TAG_W-1:0]   removed_tag;
		logic [SCORE_W-1:0] removed_score;
		logic               head_valid;
		logic [TAG_W-1:0]   head_tag;
		logic [SCORE_W-1:0] head_score;
		logic [OCC_W-1:0]   occupancy;
	} rsp_beat_t;

	typedef struct packed {
		logic               op;
		logic [LEVEL_W-1:0] level;
		logic [TAG_W-1:0]   tag;
		logic               typed;
		rsp_beat_t          want;
	} stim_row_t;

	localparam rsp_beat_t NO_WANT = '0;

	logic clk;
	logic arst_n;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	stable_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// directed beats; the want column is only used where typed is set
	stim_row_t dir_table [0:24] = '{
		'{MODE_REMOVE, 3'd0, 16'h0000, 1'b1,
			'{ST_EMPTY, 16'h0000, 7'd0, 1'b0, 16'h0000, 7'd0, 5'd0}},
		'{MODE_INSERT, 3'd0, 16'hFFFF, 1'b1,
			'{ST_OK, 16'h0000, 7'd0, 1'b1, 16'hFFFF, 7'd100, 5'd1}},
		'{MODE_REMOVE, 3'd0, 16'h0000, 1'b1,
			'{ST_OK, 16'hFFFF, 7'd100, 1'b0, 16'h0000, 7'd0, 5'd0}},
		'{MODE_INSERT, 3'd7, 16'h0000, 1'b1,
			'{ST_OK, 16'h0000, 7'd0, 1'b1, 16'h0000, 7'd20, 5'd1}},
		'{MODE_INSERT, 3'd6, 16'h0001, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd5, 16'h1234, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd3, 16'hAAAA, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd1, 16'h5555, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd3, 16'h0F0F, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd2, 16'h8000, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd4, 16'h7FFF, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd1, 16'hFFFE, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd2, 16'h0002, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd4, 16'hC3C3, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd5, 16'h3C3C, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd3, 16'h0100, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd7, 16'hFFFF, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd0, 16'h0000, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd4, 16'hDEAD, 1'b0, NO_WANT},
		// queue is full from here: both inserts get dropped
		'{MODE_INSERT, 3'd1, 16'hBEEF, 1'b0, NO_WANT},
		'{MODE_INSERT, 3'd5, 16'h0000, 1'b0, NO_WANT},
		'{MODE_REMOVE, 3'd0, 16'h0000, 1'b0, NO_WANT},
		'{MODE_REMOVE, 3'd7, 16'hFFFF, 1'b0, NO_WANT},
		'{MODE_REMOVE, 3'd0, 16'h0000, 1'b0, NO_WANT},
		'{MODE_REMOVE, 3'd0, 16'h0000, 1'b0, NO_WANT}
	};

	// shadow of the sorted queue, head at index zero
	logic [TAG_W-1:0]   held_tag   [DEPTH];
	logic [SCORE_W-1:0] held_score [DEPTH];
	int                 held_count = 0;

	rsp_beat_t awaited[$];
	int        mismatches = 0;

	logic hold_rsp  = 1'b0;
	bit   tx_idling = 1'b1;
	bit   rx_idling = 1'b1;

	function automatic rsp_beat_t queue_step(input logic op, input logic [LEVEL_W-1:0] level,
			input logic [TAG_W-1:0] tag);
		rsp_beat_t r;
		int lv;
		int score;
		int pos;
		r = '0;
		r.status = ST_OK;
		if (op == MODE_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				lv = (level == 0) ? 1 : (level > 5) ? 5 : int'(level);
				score = (6 - lv) * 20;
				pos = 0;
				// equal scores stay ahead, so arrival order holds within a score
				while (pos < held_count && int'(held_score[pos]) >= score)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_tag[i]   = held_tag[i-1];
					held_score[i] = held_score[i-1];
				end
				held_tag[pos]   = tag;
				held_score[pos] = score[SCORE_W-1:0];
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed_tag   = held_tag[0];
				r.removed_score = held_score[0];
				for (int i = 1; i < held_count; i++) begin
					held_tag[i-1]   = held_tag[i];
					held_score[i-1] = held_score[i];
				end
				held_count--;
			end
		end
		if (held_count > 0) begin
			r.head_valid = 1'b1;
			r.head_tag   = held_tag[0];
			r.head_score = held_score[0];
		end
		r.occupancy = held_count[OCC_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input int beat, input string name, input logic [TAG_W-1:0] seen,
			input logic [TAG_W-1:0] want);
		if (seen !== want)
			report_mismatch($sformatf("response beat %0d: %s is %0h, expected %0h",
				beat, name, seen, want));
	endtask

	task automatic offer_beat(input logic op, input logic [LEVEL_W-1:0] level,
			input logic [TAG_W-1:0] tag, input logic typed, input rsp_beat_t want);
		rsp_beat_t predicted;
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= op;
		req_ch.urgency_level <= level;
		req_ch.entry_tag     <= tag;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = queue_step(op, level, tag);
		awaited.push_back(typed ? want : predicted);
	endtask

	task automatic idle_sender(input int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request side
	initial begin
		int   ins_pct;
		int   burst_left;
		logic op;
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_INSERT;
		req_ch.urgency_level = '0;
		req_ch.entry_tag     = '0;
		ins_pct = 50;
		burst_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (dir_table[i]) begin
			offer_beat(dir_table[i].op, dir_table[i].level, dir_table[i].tag,
				dir_table[i].typed, dir_table[i].want);
			if ($urandom_range(0, 2) == 0)
				idle_sender(pick_gap());
		end
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// every hundred beats: new insert/remove balance and idling pattern
			if (n % 100 == 0) begin
				case ($urandom_range(0, 4))
					0: ins_pct = 90;
					1: ins_pct = 70;
					2: ins_pct = 50;
					3: ins_pct = 30;
					default: ins_pct = 10;
				endcase
				tx_idling = ($urandom_range(0, 3) != 0);
				rx_idling = ($urandom_range(0, 3) != 0);
			end
			// long response stall while requests keep coming, so the input backs up
			if (n == 300 || n == 1100) begin
				hold_rsp = 1'b1;
				burst_left = 40;
			end
			if (n == 700 || n == 1500)
				wait_for_drain();
			op = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
			offer_beat(op, LEVEL_W'($urandom_range(0, 7)), TAG_W'($urandom_range(0, 65535)),
				1'b0, NO_WANT);
			if (burst_left > 0)
				burst_left--;
			else if (tx_idling && $urandom_range(0, 3) == 0)
				idle_sender(pick_gap());
		end
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// response side: checks every beat and throttles ready
	initial begin
		rsp_beat_t want;
		int        stall_left;
		int        beat_no;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		beat_no = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (awaited.size() == 0) begin
					report_mismatch($sformatf("response beat %0d with no request outstanding",
						beat_no));
				end else begin
					want = awaited.pop_front();
					check_field(beat_no, "status", TAG_W'(rsp_ch.status),
						TAG_W'(want.status));
					check_field(beat_no, "removed_tag", rsp_ch.removed_tag, want.removed_tag);
					check_field(beat_no, "removed_score", TAG_W'(rsp_ch.removed_score),
						TAG_W'(want.removed_score));
					check_field(beat_no, "head_valid", TAG_W'(rsp_ch.head_valid),
						TAG_W'(want.head_valid));
					check_field(beat_no, "head_tag", rsp_ch.head_tag, want.head_tag);
					check_field(beat_no, "head_score", TAG_W'(rsp_ch.head_score),
						TAG_W'(want.head_score));
					check_field(beat_no, "occupancy", TAG_W'(rsp_ch.occupancy),
						TAG_W'(want.occupancy));
				end
				beat_no++;
			end
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rx_idling && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog: too long without a beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
